### rtl/core/tkre_pkg.sv
package tkre_pkg;

   localparam int RADIUS_DEF     = 10;
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int POS_W      = 9;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 4 * BYTE_W;
   localparam int CFG_DIM_W  = 10;
   localparam int CFG_LIM_W  = 18;
   localparam int CFG_IDX_W  = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - BYTE_W - 2;

   localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 10'd512;
   localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 10'd512;
   localparam logic [CFG_LIM_W-1:0] COLOR_LIMIT_RST  = 18'd25;

   localparam logic [BYTE_W-1:0] KNOWN_BG = 8'd0;
   localparam logic [BYTE_W-1:0] KNOWN_FG = 8'd255;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } tkre_cmd_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_COLOR_LIMIT  = 2'd2
   } tkre_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SEARCH,
      ST_DRAIN,
      ST_DONE
   } tkre_state_type;

   typedef enum logic {
      PH_ROWS,
      PH_COLS
   } tkre_phase_type;

   function automatic logic is_known(logic [BYTE_W-1:0] t);
      return (t == KNOWN_BG) || (t == KNOWN_FG);
   endfunction

endpackage

### rtl/core/tkre_ram.sv
module tkre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/trimap_known_region_expansion_top.sv
// Trimap known-region expansion over a stored frame.
// req channel: one item per pixel. tuser = command (0 write, 1 query).
//   A write stores trimap byte and RGB at (row, col); a query returns the
//   expanded label of the pixel at (row, col).
// rsp channel: exactly one item per request, in request order: label,
//   expanded flag and still-unknown flag (all zero for a write).
// csr port: frame_width, frame_height, color_limit_sq; write while idle.
// An unknown pixel walks square rings k = 0..RADIUS, one candidate read per
//   cycle from the single read port of the frame memory, and stops once the
//   compare pipeline finds the first hit; with no hit it ends once the last
//   ring has drained from the compare pipeline.
// One request is in flight at a time: req_tready is high only while idle.
// The result sits in an output register, so the next request is taken
//   while a result waits; a stalled rsp_tready holds that result and the
//   block stops before loading the next one.
// Reset clears control state and restores the csr defaults; the frame
//   memory is not cleared and must be written before it is queried.
module trimap_known_region_expansion_top #(
   parameter int RADIUS     = tkre_pkg::RADIUS_DEF,
   parameter int MAX_WIDTH  = tkre_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = tkre_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row[8:0], col[17:9], trimap_value[25:18], red[33:26], green[41:34],
   // blue[49:42], zero pad[55:50]
   input  logic [tkre_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // label[7:0], expanded[8], still_unknown[9], zero pad[15:10]
   output logic [tkre_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [tkre_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [tkre_pkg::CFG_LIM_W-1:0]   csr_wdata
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int CW      = ($clog2(MAX_DIM) > tkre_pkg::POS_W) ?
                            $clog2(MAX_DIM) : tkre_pkg::POS_W;
   localparam int EW      = (CW + 1 > tkre_pkg::CFG_DIM_W) ? CW + 1 : tkre_pkg::CFG_DIM_W;
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(DEPTH);
   localparam int KW      = $clog2(RADIUS + 1);
   localparam int SW      = 2 * KW + 1;
   localparam int BW      = tkre_pkg::BYTE_W;
   localparam int SQ_W    = 2 * BW;
   localparam int SUM_W   = SQ_W + 2;

   function automatic logic [AW-1:0] pix_addr(logic [CW-1:0] r, logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
   endfunction

   function automatic logic [BW-1:0] byte_dist(logic [BW-1:0] a, logic [BW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [CW-1:0] pos_dist(logic [CW-1:0] a, logic [CW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // request fields
   logic [tkre_pkg::POS_W-1:0]  req_row;
   logic [tkre_pkg::POS_W-1:0]  req_col;
   logic [tkre_pkg::WORD_W-1:0] req_word;
   logic                        req_accept;
   logic                        req_is_query;
   logic                        req_in_frame;
   logic                        req_in_store;

   assign req_row      = req_tdata[8:0];
   assign req_col      = req_tdata[17:9];
   assign req_word     = {req_tdata[25:18], req_tdata[33:26],
                          req_tdata[41:34], req_tdata[49:42]};
   assign req_accept   = req_tvalid && req_tready;
   assign req_is_query = (tkre_pkg::tkre_cmd_type'(req_tuser) == tkre_pkg::CMD_QUERY);

   // configuration
   logic [tkre_pkg::CFG_DIM_W-1:0] frame_width_ff;
   logic [tkre_pkg::CFG_DIM_W-1:0] frame_height_ff;
   logic [tkre_pkg::CFG_LIM_W-1:0] color_limit_ff;
   logic [CW-1:0]                  wm1;
   logic [CW-1:0]                  hm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= tkre_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= tkre_pkg::FRAME_HEIGHT_RST;
         color_limit_ff  <= tkre_pkg::COLOR_LIMIT_RST;
      end else if (csr_we) begin
         unique case (tkre_pkg::tkre_csr_type'(csr_index))
            tkre_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[tkre_pkg::CFG_DIM_W-1:0];
            end
            tkre_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[tkre_pkg::CFG_DIM_W-1:0];
            end
            tkre_pkg::CSR_COLOR_LIMIT: begin
               color_limit_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // clamp frame size to 1..MAX, keep last index
   always_comb begin
      if (frame_width_ff == '0) begin
         wm1 = '0;
      end else if (EW'(frame_width_ff) > EW'(MAX_WIDTH)) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(EW'(frame_width_ff) - EW'(1));
      end
      if (frame_height_ff == '0) begin
         hm1 = '0;
      end else if (EW'(frame_height_ff) > EW'(MAX_HEIGHT)) begin
         hm1 = CW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = CW'(EW'(frame_height_ff) - EW'(1));
      end
   end

   assign req_in_frame = (EW'(req_row) <= EW'(hm1)) && (EW'(req_col) <= EW'(wm1));
   assign req_in_store = (EW'(req_row) < EW'(MAX_HEIGHT)) && (EW'(req_col) < EW'(MAX_WIDTH));

   // control and sequencer state
   tkre_pkg::tkre_state_type state_ff, state_in;
   tkre_pkg::tkre_phase_type phase_ff, phase_in;
   logic                     side_ff, side_in;
   logic [KW-1:0]            k_ff, k_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            r0_ff, r0_in;
   logic [CW-1:0]            r1_ff, r1_in;
   logic [CW-1:0]            c0_ff, c0_in;
   logic [CW-1:0]            c1_ff, c1_in;
   logic [CW-1:0]            qrow_ff, qrow_in;
   logic [CW-1:0]            qcol_ff, qcol_in;
   logic [tkre_pkg::WORD_W-1:0] center_ff, center_in;
   logic [BW-1:0]            res_label_ff, res_label_in;
   logic                     res_exp_ff, res_exp_in;
   logic                     res_unk_ff, res_unk_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]            rsp_label_ff, rsp_label_in;
   logic                     rsp_exp_ff, rsp_exp_in;
   logic                     rsp_unk_ff, rsp_unk_in;

   // compare pipeline
   logic                     p1_valid_ff, p1_valid_in;
   logic [CW-1:0]            p1_row_ff, p1_row_in;
   logic [CW-1:0]            p1_col_ff, p1_col_in;
   logic                     p2_valid_ff, p2_valid_in;
   logic                     p2_ok_ff, p2_ok_in;
   logic [BW-1:0]            p2_label_ff, p2_label_in;
   logic [SQ_W-1:0]          p2_sq_r_ff, p2_sq_r_in;
   logic [SQ_W-1:0]          p2_sq_g_ff, p2_sq_g_in;
   logic [SQ_W-1:0]          p2_sq_b_ff, p2_sq_b_in;

   // memory
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [AW-1:0]               ram_raddr;
   logic [tkre_pkg::WORD_W-1:0] ram_rdata;

   tkre_ram #(
      .WIDTH (tkre_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_word),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // current candidate of the ring walk
   logic [CW-1:0] probe_row;
   logic [CW-1:0] probe_col;
   logic          gen_last;
   logic          pipe_empty;
   logic          out_free;
   logic          eval_on;
   logic          hit;
   logic          center_known;

   assign probe_row = (phase_ff == tkre_pkg::PH_ROWS) ? idx_ff : (side_ff ? r1_ff : r0_ff);
   assign probe_col = (phase_ff == tkre_pkg::PH_ROWS) ? (side_ff ? c1_ff : c0_ff) : idx_ff;
   assign gen_last  = side_ff && (phase_ff == tkre_pkg::PH_COLS) && (idx_ff == c1_ff) &&
                      (k_ff == KW'(RADIUS));
   assign pipe_empty   = !p1_valid_ff && !p2_valid_ff;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign center_known = tkre_pkg::is_known(ram_rdata[31:24]);

   assign ram_we    = req_accept && !req_is_query && req_in_store;
   assign ram_waddr = pix_addr(CW'(req_row), CW'(req_col));
   assign ram_raddr = (state_ff == tkre_pkg::ST_IDLE) ?
                      pix_addr(CW'(req_row), CW'(req_col)) : pix_addr(probe_row, probe_col);

   // stage 1: candidate word from memory
   logic [BW-1:0]   s1_trimap;
   logic [KW-1:0]   s1_dr;
   logic [KW-1:0]   s1_dc;
   logic [SW-1:0]   s1_space;

   assign s1_trimap = ram_rdata[31:24];
   assign s1_dr     = KW'(pos_dist(p1_row_ff, qrow_ff));
   assign s1_dc     = KW'(pos_dist(p1_col_ff, qcol_ff));
   assign s1_space  = SW'(s1_dr) * SW'(s1_dr) + SW'(s1_dc) * SW'(s1_dc);

   always_comb begin
      p2_ok_in    = tkre_pkg::is_known(s1_trimap) && (s1_space <= SW'(RADIUS * RADIUS));
      p2_label_in = s1_trimap;
      p2_sq_r_in  = SQ_W'(byte_dist(ram_rdata[23:16], center_ff[23:16])) *
                    SQ_W'(byte_dist(ram_rdata[23:16], center_ff[23:16]));
      p2_sq_g_in  = SQ_W'(byte_dist(ram_rdata[15:8], center_ff[15:8])) *
                    SQ_W'(byte_dist(ram_rdata[15:8], center_ff[15:8]));
      p2_sq_b_in  = SQ_W'(byte_dist(ram_rdata[7:0], center_ff[7:0])) *
                    SQ_W'(byte_dist(ram_rdata[7:0], center_ff[7:0]));
   end

   // stage 2: colour distance
   logic [SUM_W-1:0] s2_color;

   assign s2_color = SUM_W'(p2_sq_r_ff) + SUM_W'(p2_sq_g_ff) + SUM_W'(p2_sq_b_ff);
   assign eval_on  = (state_ff == tkre_pkg::ST_SEARCH) || (state_ff == tkre_pkg::ST_DRAIN);
   assign hit      = eval_on && p2_valid_ff && p2_ok_ff &&
                     (s2_color <= SUM_W'(color_limit_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkre_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_is_query && req_in_frame) ? tkre_pkg::ST_CENTER :
                                                           tkre_pkg::ST_DONE;
            end
         end
         tkre_pkg::ST_CENTER: begin
            state_in = center_known ? tkre_pkg::ST_DONE : tkre_pkg::ST_SEARCH;
         end
         tkre_pkg::ST_SEARCH: begin
            priority if (hit) begin
               state_in = tkre_pkg::ST_DONE;
            end else if (gen_last) begin
               state_in = tkre_pkg::ST_DRAIN;
            end else begin
               state_in = tkre_pkg::ST_SEARCH;
            end
         end
         tkre_pkg::ST_DRAIN: begin
            if (hit || pipe_empty) begin
               state_in = tkre_pkg::ST_DONE;
            end
         end
         tkre_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tkre_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tkre_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in     = phase_ff;
      side_in      = side_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      qrow_in      = qrow_ff;
      qcol_in      = qcol_ff;
      center_in    = center_ff;
      res_label_in = res_label_ff;
      res_exp_in   = res_exp_ff;
      res_unk_in   = res_unk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_label_in = rsp_label_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_unk_in   = rsp_unk_ff;
      p1_valid_in  = 1'b0;
      p1_row_in    = probe_row;
      p1_col_in    = probe_col;
      p2_valid_in  = p1_valid_ff && !hit;

      unique case (state_ff)
         tkre_pkg::ST_IDLE: begin
            if (req_accept) begin
               qrow_in      = CW'(req_row);
               qcol_in      = CW'(req_col);
               res_label_in = '0;
               res_exp_in   = 1'b0;
               res_unk_in   = 1'b0;
            end
         end
         tkre_pkg::ST_CENTER: begin
            center_in    = ram_rdata;
            res_label_in = ram_rdata[31:24];
            phase_in     = tkre_pkg::PH_ROWS;
            side_in      = 1'b0;
            k_in         = '0;
            idx_in       = qrow_ff;
            r0_in        = qrow_ff;
            r1_in        = qrow_ff;
            c0_in        = qcol_ff;
            c1_in        = qcol_ff;
         end
         tkre_pkg::ST_SEARCH: begin
            if (hit) begin
               res_label_in = p2_label_ff;
               res_exp_in   = 1'b1;
            end else begin
               p1_valid_in = 1'b1;
               if (!side_ff) begin
                  side_in = 1'b1;
               end else begin
                  side_in = 1'b0;
                  if (phase_ff == tkre_pkg::PH_ROWS) begin
                     if (idx_ff == r1_ff) begin
                        phase_in = tkre_pkg::PH_COLS;
                        idx_in   = c0_ff;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end else if (idx_ff != c1_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end else if (!gen_last) begin
                     // widen the ring by one, clamped to the frame
                     k_in     = k_ff + 1'b1;
                     phase_in = tkre_pkg::PH_ROWS;
                     r0_in    = (r0_ff == '0) ? r0_ff : r0_ff - 1'b1;
                     r1_in    = (r1_ff == hm1) ? r1_ff : r1_ff + 1'b1;
                     c0_in    = (c0_ff == '0) ? c0_ff : c0_ff - 1'b1;
                     c1_in    = (c1_ff == wm1) ? c1_ff : c1_ff + 1'b1;
                     idx_in   = (r0_ff == '0) ? r0_ff : r0_ff - 1'b1;
                  end
               end
            end
         end
         tkre_pkg::ST_DRAIN: begin
            if (hit) begin
               res_label_in = p2_label_ff;
               res_exp_in   = 1'b1;
            end else if (pipe_empty) begin
               res_unk_in = 1'b1;
            end
         end
         tkre_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_label_in = res_label_ff;
               rsp_exp_in   = res_exp_ff;
               rsp_unk_in   = res_unk_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkre_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      side_ff      <= side_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      qrow_ff      <= qrow_in;
      qcol_ff      <= qcol_in;
      center_ff    <= center_in;
      res_label_ff <= res_label_in;
      res_exp_ff   <= res_exp_in;
      res_unk_ff   <= res_unk_in;
      rsp_label_ff <= rsp_label_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_unk_ff   <= rsp_unk_in;
      p1_row_ff    <= p1_row_in;
      p1_col_ff    <= p1_col_in;
      p2_ok_ff     <= p2_ok_in;
      p2_label_ff  <= p2_label_in;
      p2_sq_r_ff   <= p2_sq_r_in;
      p2_sq_g_ff   <= p2_sq_g_in;
      p2_sq_b_ff   <= p2_sq_b_in;
   end

   assign req_tready = (state_ff == tkre_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{tkre_pkg::RSP_PAD_W{1'b0}}, rsp_unk_ff, rsp_exp_ff, rsp_label_ff};

endmodule

### rtl/core/tkre_port_check.sv
module tkre_port_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tkre_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("expanded and still_unknown both set");

   a_exp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |->
         (rsp_tdata[7:0] == tkre_pkg::KNOWN_BG) || (rsp_tdata[7:0] == tkre_pkg::KNOWN_FG))
      else $error("expanded label is not a known value");

   a_unk_label: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |->
         (rsp_tdata[7:0] != tkre_pkg::KNOWN_BG) && (rsp_tdata[7:0] != tkre_pkg::KNOWN_FG))
      else $error("still_unknown with a known label");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

endmodule

bind trimap_known_region_expansion_top tkre_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/trimap_known_region_expansion_top_tb.sv
`timescale 1ns / 100ps

module trimap_known_region_expansion_top_tb;
   import tkre_pkg::*;

   localparam int RADIUS = RADIUS_DEF;
   localparam int MAX_W = MAX_WIDTH_DEF;
   localparam int MAX_H = MAX_HEIGHT_DEF;
   localparam int RANDOM_ITEMS = 1360;
   localparam logic [CFG_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] label;
      logic              expanded;
      logic              still_unknown;
   } label_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_LIM_W-1:0] csr_wdata = '0;

   logic [WORD_W-1:0] pix_mem [0:MAX_W*MAX_H-1];
   bit pix_written [0:MAX_W*MAX_H-1];
   logic [CFG_DIM_W-1:0] cfg_width = FRAME_WIDTH_RST;
   logic [CFG_DIM_W-1:0] cfg_height = FRAME_HEIGHT_RST;
   logic [CFG_LIM_W-1:0] cfg_limit = COLOR_LIMIT_RST;
   logic [23:0] palette [0:3];

   label_result_type pending_labels [$];
   label_result_type got, want;
   int fail_count = 0;
   int item_count = 0;
   int rsp_stall_left = 0;
   bit req_idle_en = 1'b1;
   bit rsp_stall_en = 1'b1;

   trimap_known_region_expansion_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int clamp_dim(logic [CFG_DIM_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic int color_dist_sq(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      int sum, i, d;
      sum = 0;
      for (i = 0; i < 3; i++) begin
         d = int'(a[i*8 +: 8]) - int'(b[i*8 +: 8]);
         sum += d * d;
      end
      return sum;
   endfunction

   function automatic bit neighbour_hit(int qr, int qc, logic [WORD_W-1:0] ctr, int r, int c,
                                        output logic [BYTE_W-1:0] lab);
      logic [WORD_W-1:0] w;
      int dr, dc;
      w = pix_mem[r*MAX_W + c];
      lab = w[31:24];
      dr = r - qr;
      dc = c - qc;
      if (lab != KNOWN_BG && lab != KNOWN_FG) return 1'b0;
      if (dr * dr + dc * dc > RADIUS * RADIUS) return 1'b0;
      if (color_dist_sq(ctr, w) > cfg_limit) return 1'b0;
      return 1'b1;
   endfunction

   function automatic label_result_type expand_label(int row, int col);
      label_result_type res;
      logic [WORD_W-1:0] ctr;
      logic [BYTE_W-1:0] t, lab;
      int w, h, k, r0, r1, c0, c1, r, c;
      bit hit;
      res = '0;
      hit = 1'b0;
      lab = '0;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      if (row >= h || col >= w) return res;
      ctr = pix_mem[row*MAX_W + col];
      t = ctr[31:24];
      if (t == KNOWN_BG || t == KNOWN_FG) begin
         res.label = t;
         return res;
      end
      for (k = 0; k <= RADIUS && !hit; k++) begin
         r0 = (row - k < 0) ? 0 : row - k;
         r1 = (row + k > h - 1) ? h - 1 : row + k;
         c0 = (col - k < 0) ? 0 : col - k;
         c1 = (col + k > w - 1) ? w - 1 : col + k;
         for (r = r0; r <= r1 && !hit; r++) begin
            hit = neighbour_hit(row, col, ctr, r, c0, lab);
            if (!hit) hit = neighbour_hit(row, col, ctr, r, c1, lab);
         end
         for (c = c0; c <= c1 && !hit; c++) begin
            hit = neighbour_hit(row, col, ctr, r0, c, lab);
            if (!hit) hit = neighbour_hit(row, col, ctr, r1, c, lab);
         end
      end
      if (hit) begin
         res.label = lab;
         res.expanded = 1'b1;
      end else begin
         res.label = t;
         res.still_unknown = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] random_pixel();
      logic [BYTE_W-1:0] t;
      logic [23:0] rgb;
      int sel, i, v;
      sel = $urandom_range(0, 99);
      if (sel < 35) t = KNOWN_BG;
      else if (sel < 70) t = KNOWN_FG;
      else if (sel < 73) t = 8'd1;
      else if (sel < 76) t = 8'd254;
      else t = 8'($urandom_range(1, 254));
      if ($urandom_range(0, 9) == 0) begin
         rgb = 24'($urandom);
      end else begin
         rgb = palette[$urandom_range(0, 3)];
         for (i = 0; i < 3; i++) begin
            v = int'(rgb[i*8 +: 8]) + int'($urandom_range(0, 8)) - 4;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            rgb[i*8 +: 8] = v[7:0];
         end
      end
      return {t, rgb};
   endfunction

   function automatic int next_gap();
      int sel;
      if (!req_idle_en) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 60) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [CFG_LIM_W-1:0] pick_dim();
      logic [CFG_DIM_W-1:0] d;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) d = '0;
      else if (sel < 14) d = 10'd1;
      else d = 10'($urandom_range(2, 28));
      return {8'($urandom), d};
   endfunction

   function automatic logic [CFG_LIM_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 18'd25;
         2: return 18'd195075;
         3: return '1;
         4: return 18'($urandom_range(0, 400));
         default: return 18'($urandom_range(0, 5000));
      endcase
   endfunction

   task automatic new_palette();
      int i;
      for (i = 0; i < 4; i++) palette[i] = 24'($urandom);
      if ($urandom_range(0, 1) == 1) palette[1] = palette[0] ^ 24'h030201;
   endtask

   task automatic send_item(tkre_cmd_type cmd, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                            logic [WORD_W-1:0] pix);
      int gap, idx;
      gap = next_gap();
      idx = int'(row) * MAX_W + int'(col);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {6'b0, pix[7:0], pix[15:8], pix[23:16], pix[31:24], col, row};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_WRITE) begin
         pix_mem[idx] = pix;
         pix_written[idx] = 1'b1;
         pending_labels.insert(pending_labels.size(), label_result_type'(0));
      end else begin
         pending_labels.insert(pending_labels.size(), expand_label(int'(row), int'(col)));
      end
      item_count++;
   endtask

   task automatic write_pixel(int row, int col, logic [WORD_W-1:0] pix);
      send_item(CMD_WRITE, 9'(row), 9'(col), pix);
   endtask

   // fill every unwritten pixel that the search around (row, col) may read
   task automatic fill_window(int row, int col);
      int w, h, r, c;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      for (r = (row > RADIUS) ? row - RADIUS : 0; r <= row + RADIUS && r < h; r++)
         for (c = (col > RADIUS) ? col - RADIUS : 0; c <= col + RADIUS && c < w; c++)
            if (!pix_written[r*MAX_W + c]) write_pixel(r, c, random_pixel());
   endtask

   task automatic query_pixel(int row, int col);
      int w, h, idx;
      logic [BYTE_W-1:0] t;
      w = clamp_dim(cfg_width, MAX_W);
      h = clamp_dim(cfg_height, MAX_H);
      idx = row * MAX_W + col;
      t = pix_mem[idx][31:24];
      if (row < h && col < w && !(pix_written[idx] && (t == KNOWN_BG || t == KNOWN_FG)))
         fill_window(row, col);
      send_item(CMD_QUERY, 9'(row), 9'(col), $urandom);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_LIM_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: cfg_width = value[CFG_DIM_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = value[CFG_DIM_W-1:0];
         CSR_COLOR_LIMIT: cfg_limit = value;
         default: ;
      endcase
   endtask

   task automatic test_store_corners();
      write_pixel(0, 0, {KNOWN_BG, 24'h000000});
      write_pixel(511, 511, {KNOWN_FG, 24'hFFFFFF});
      write_pixel(511, 0, {KNOWN_FG, 24'hFF00FF});
      query_pixel(511, 511);
      query_pixel(0, 0);
      query_pixel(511, 0);
   endtask

   task automatic test_frame_clamp();
      drain_results();
      csr_write(CSR_FRAME_WIDTH, 18'd0);
      csr_write(CSR_FRAME_HEIGHT, 18'd4);
      csr_write(CSR_COLOR_LIMIT, 18'd25);
      write_pixel(0, 0, {8'd1, 24'h102030});
      write_pixel(1, 0, {8'd128, 24'h405060});
      write_pixel(2, 0, {KNOWN_BG, 24'h000000});
      write_pixel(3, 0, {KNOWN_FG, 24'h425162});
      query_pixel(1, 0);
      query_pixel(0, 1);
      query_pixel(4, 0);
      drain_results();
      csr_write(CSR_FRAME_WIDTH, {8'hFF, 10'h3FF});
      csr_write(CSR_FRAME_HEIGHT, 18'd0);
      csr_write(CSR_UNMAPPED, 18'd1);
      write_pixel(0, 511, {KNOWN_FG, 24'h00FF00});
      query_pixel(0, 511);
      query_pixel(1, 5);
   endtask

   task automatic test_color_match();
      drain_results();
      csr_write(CSR_FRAME_WIDTH, 18'd3);
      csr_write(CSR_FRAME_HEIGHT, 18'd1);
      csr_write(CSR_COLOR_LIMIT, 18'd0);
      write_pixel(0, 0, {8'd254, 24'hABCDEF});
      write_pixel(0, 1, {8'd77, 24'h000001});
      write_pixel(0, 2, {KNOWN_FG, 24'hABCDEF});
      query_pixel(0, 0);
      query_pixel(0, 1);
      drain_results();
      csr_write(CSR_COLOR_LIMIT, '1);
      query_pixel(0, 1);
   endtask

   task automatic test_full_frame();
      drain_results();
      csr_write(CSR_FRAME_WIDTH, 18'd512);
      csr_write(CSR_FRAME_HEIGHT, {8'h5A, 10'h3FF});
      csr_write(CSR_COLOR_LIMIT, 18'd3000);
      new_palette();
      write_pixel(510, 509, {8'd100, palette[0]});
      query_pixel(510, 509);
      query_pixel(511, 511);
      query_pixel(508, 506);
      write_pixel(4, 505, {8'd200, palette[1]});
      query_pixel(4, 505);
      query_pixel(0, 511);
   endtask

   task automatic test_random_frames(int total);
      int n, i, sel, w, h;
      while (item_count < total) begin
         drain_results();
         csr_write(CSR_FRAME_WIDTH, pick_dim());
         csr_write(CSR_FRAME_HEIGHT, pick_dim());
         csr_write(CSR_COLOR_LIMIT, pick_limit());
         new_palette();
         req_idle_en = ($urandom_range(0, 3) != 0);
         rsp_stall_en = ($urandom_range(0, 3) != 0);
         w = clamp_dim(cfg_width, MAX_W);
         h = clamp_dim(cfg_height, MAX_H);
         n = $urandom_range(30, 80);
         for (i = 0; i < n && item_count < total; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
               query_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1));
            end else if (sel < 85) begin
               write_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1), random_pixel());
            end else if (sel < 93) begin
               write_pixel($urandom_range(0, MAX_H - 1), $urandom_range(0, MAX_W - 1),
                           random_pixel());
            end else begin
               query_pixel($urandom_range(0, MAX_H - 1), $urandom_range(0, MAX_W - 1));
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_en && $urandom_range(0, 99) < 20) begin
         rsp_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.label = rsp_tdata[7:0];
         got.expanded = rsp_tdata[8];
         got.still_unknown = rsp_tdata[9];
         if (pending_labels.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_labels.pop_front();
            if (got.label !== want.label) begin
               $display("%0t: label expected %0d actual %0d", $time, want.label, got.label);
               fail_count++;
            end
            if (got.expanded !== want.expanded) begin
               $display("%0t: expanded expected %0b actual %0b", $time, want.expanded,
                        got.expanded);
               fail_count++;
            end
            if (got.still_unknown !== want.still_unknown) begin
               $display("%0t: still_unknown expected %0b actual %0b", $time,
                        want.still_unknown, got.still_unknown);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int random_start;
      new_palette();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_store_corners();
      test_frame_clamp();
      test_color_match();
      random_start = item_count;
      test_full_frame();
      test_random_frames(random_start + RANDOM_ITEMS);
      drain_results();
      repeat (30) @(posedge clock);
      if (pending_labels.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_labels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
